### rtl/core/jws_pkg.sv
// jws_pkg: shared types and constants for the jaro-winkler similarity core
// no dependencies; used by jws_ctrl, jws_dp and jaro_winkler_similarity_core

package jws_pkg;

    localparam int MAX_LEN_DEF = 64;

    localparam logic [16:0] ONE_Q16        = 17'h10000;
    localparam logic [16:0] THRESHOLD_DEF  = 17'd45875;
    localparam logic [3:0]  PREFIX_LIM_DEF = 4'd4;
    localparam logic [13:0] PREFIX_SCL_DEF = 14'd6554;

    localparam logic [1:0] OP_APPEND_FIRST  = 2'd0;
    localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
    localparam logic [1:0] OP_COMPARE       = 2'd2;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_PREFIX_LIM = 2'd1;
    localparam logic [1:0] REG_PREFIX_SCL = 2'd2;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_APPEND,
        CMD_START,
        CMD_ROW_INIT,
        CMD_NEXT_ROW,
        CMD_HIT,
        CMD_J_INC,
        CMD_I_INC,
        CMD_T_INIT,
        CMD_T_CMP,
        CMD_AR1,
        CMD_AR2,
        CMD_AR3,
        CMD_AR4,
        CMD_AR5,
        CMD_AR6,
        CMD_DIV_STEP,
        CMD_SET_W,
        CMD_B1,
        CMD_B2,
        CMD_B3,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        logic l1_zero;
        logic row_done;
        logic win_empty;
        logic hit;
        logic win_last;
        logic fm_i;
        logic k_in;
        logic sm_k;
        logic common_zero;
        logic div_last;
        logic boost;
        logic pre_done;
        logic pre_eq;
    } dp_status_t;

endpackage

### rtl/core/jws_ram.sv
// jws_ram: generic single-write, single-read ram with registered read data
// no dependencies

module jws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/jws_ctrl.sv
// jws_ctrl: sequencer for append, match walk, transposition scan, multiply steps, division and boost
// depends on jws_pkg

module jws_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic [1:0]             opcode,
    input  logic                   result_ready,
    input  jws_pkg::dp_status_t    status,
    output logic                   item_ready,
    output logic                   result_valid,
    output jws_pkg::cmd_t          cmd
);

    typedef enum logic [20:0] {
        S_IDLE = 21'h000001,
        S_MROW = 21'h000002,
        S_MRD  = 21'h000004,
        S_MCMP = 21'h000008,
        S_TSCN = 21'h000010,
        S_TCMP = 21'h000020,
        S_AR1  = 21'h000040,
        S_AR2  = 21'h000080,
        S_AR3  = 21'h000100,
        S_AR4  = 21'h000200,
        S_AR5  = 21'h000400,
        S_AR6  = 21'h000800,
        S_DIV  = 21'h001000,
        S_BCHK = 21'h002000,
        S_PCHK = 21'h004000,
        S_PCMP = 21'h008000,
        S_B1   = 21'h010000,
        S_B2   = 21'h020000,
        S_B3   = 21'h040000,
        S_EMIT = 21'h080000,
        S_SPARE = 21'h100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   emit;

    always_comb
    begin
        state_next = state_reg;
        cmd        = jws_pkg::CMD_NONE;
        emit       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (opcode)
                        jws_pkg::OP_APPEND_FIRST, jws_pkg::OP_APPEND_SECOND:
                        begin
                            cmd = jws_pkg::CMD_APPEND;
                        end
                        jws_pkg::OP_COMPARE:
                        begin
                            cmd        = jws_pkg::CMD_START;
                            state_next = status.l1_zero ? S_EMIT : S_MROW;
                        end
                        default:
                        begin
                            cmd = jws_pkg::CMD_NONE;
                        end
                    endcase
                end
            end
            S_MROW:
            begin
                if (status.row_done)
                begin
                    if (status.common_zero)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cmd        = jws_pkg::CMD_T_INIT;
                        state_next = S_TSCN;
                    end
                end
                else if (status.win_empty)
                begin
                    cmd = jws_pkg::CMD_NEXT_ROW;
                end
                else
                begin
                    cmd        = jws_pkg::CMD_ROW_INIT;
                    state_next = S_MRD;
                end
            end
            S_MRD:
            begin
                state_next = S_MCMP;
            end
            S_MCMP:
            begin
                if (status.hit)
                begin
                    cmd        = jws_pkg::CMD_HIT;
                    state_next = S_MROW;
                end
                else if (status.win_last)
                begin
                    cmd        = jws_pkg::CMD_NEXT_ROW;
                    state_next = S_MROW;
                end
                else
                begin
                    cmd        = jws_pkg::CMD_J_INC;
                    state_next = S_MRD;
                end
            end
            S_TSCN:
            begin
                if (status.row_done)
                begin
                    state_next = S_AR1;
                end
                else if (!status.fm_i)
                begin
                    cmd = jws_pkg::CMD_I_INC;
                end
                else if (status.k_in && !status.sm_k)
                begin
                    cmd = jws_pkg::CMD_J_INC;
                end
                else if (!status.k_in)
                begin
                    state_next = S_AR1;
                end
                else
                begin
                    state_next = S_TCMP;
                end
            end
            S_TCMP:
            begin
                cmd        = jws_pkg::CMD_T_CMP;
                state_next = S_TSCN;
            end
            S_AR1:
            begin
                cmd        = jws_pkg::CMD_AR1;
                state_next = S_AR2;
            end
            S_AR2:
            begin
                cmd        = jws_pkg::CMD_AR2;
                state_next = S_AR3;
            end
            S_AR3:
            begin
                cmd        = jws_pkg::CMD_AR3;
                state_next = S_AR4;
            end
            S_AR4:
            begin
                cmd        = jws_pkg::CMD_AR4;
                state_next = S_AR5;
            end
            S_AR5:
            begin
                cmd        = jws_pkg::CMD_AR5;
                state_next = S_AR6;
            end
            S_AR6:
            begin
                cmd        = jws_pkg::CMD_AR6;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd = jws_pkg::CMD_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = S_BCHK;
                end
            end
            S_BCHK:
            begin
                cmd        = jws_pkg::CMD_SET_W;
                state_next = status.boost ? S_PCHK : S_EMIT;
            end
            S_PCHK:
            begin
                state_next = status.pre_done ? S_B1 : S_PCMP;
            end
            S_PCMP:
            begin
                if (status.pre_eq)
                begin
                    cmd        = jws_pkg::CMD_I_INC;
                    state_next = S_PCHK;
                end
                else
                begin
                    state_next = S_B1;
                end
            end
            S_B1:
            begin
                cmd        = jws_pkg::CMD_B1;
                state_next = S_B2;
            end
            S_B2:
            begin
                cmd        = jws_pkg::CMD_B2;
                state_next = S_B3;
            end
            S_B3:
            begin
                cmd        = jws_pkg::CMD_B3;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd        = jws_pkg::CMD_EMIT;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;

endmodule

### rtl/core/jws_dp.sv
// jws_dp: string stores, match flags, counters, multiply steps, divider and output register
// depends on jws_pkg and jws_ram

module jws_dp #(
    parameter int MAX_LEN = jws_pkg::MAX_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  jws_pkg::cmd_t       cmd,
    input  logic [1:0]          opcode,
    input  logic [7:0]          character,
    input  logic [16:0]         boost_threshold,
    input  logic [3:0]          prefix_limit,
    input  logic [13:0]         prefix_scale,
    output jws_pkg::dp_status_t status,
    output logic [16:0]         similarity,
    output logic [16:0]         dissimilarity,
    output logic [6:0]          common_count,
    output logic [5:0]          transposition_count,
    output logic [3:0]          prefix_length,
    output logic                overflow
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int NW = 3 * LW + 2;
    localparam int PW = (LW > 4) ? LW : 4;

    logic [LW-1:0]      l1_reg, l1_next, l2_reg, l2_next;
    logic               ovf_reg, ovf_next;
    logic [LW-1:0]      i_reg, i_next, j_reg, j_next, jend_reg, jend_next;
    logic [LW-1:0]      rng_reg, rng_next;
    logic [LW-1:0]      common_reg, common_next, half_reg, half_next;
    logic [MAX_LEN-1:0] fm_reg, fm_next, sm_reg, sm_next;
    logic               pre_mode_reg, pre_mode_next;
    logic [2*LW-1:0]    cc_reg, cc_next, ll_reg, ll_next;
    logic [3*LW:0]      na_reg, na_next;
    logic [3*LW-1:0]    nb_reg, nb_next;
    logic [NW-1:0]      den_reg, den_next;
    logic [NW:0]        rem_reg, rem_next;
    logic [16:0]        q_reg, q_next, w_reg, w_next, sim_reg, sim_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [17:0]        sp_reg, sp_next;
    logic [34:0]        prod_reg, prod_next;
    logic [3:0]         plen_reg, plen_next;
    logic [16:0]        sim_out_reg, sim_out_next, dis_out_reg, dis_out_next;
    logic [6:0]         cc_out_reg, cc_out_next;
    logic [5:0]         tr_out_reg, tr_out_next;
    logic [3:0]         pl_out_reg, pl_out_next;
    logic               ov_out_reg, ov_out_next;

    logic               we_a, we_b;
    logic [7:0]         rdata_a, rdata_b;
    logic [AW-1:0]      raddr_b;
    logic [LW-1:0]      longer, half_len, rng_calc, win_start;
    logic [LW:0]        win_end_raw, win_end, j_plus;
    logic               ge;
    logic [NW:0]        rem_sub;
    logic [18:0]        boost_sum;
    logic [LW-1:0]      trans;

    assign we_a = (cmd == jws_pkg::CMD_APPEND) && (opcode == jws_pkg::OP_APPEND_FIRST)
                  && (l1_reg < LW'(MAX_LEN));
    assign we_b = (cmd == jws_pkg::CMD_APPEND) && (opcode == jws_pkg::OP_APPEND_SECOND)
                  && (l2_reg < LW'(MAX_LEN));
    assign raddr_b = pre_mode_reg ? i_reg[AW-1:0] : j_reg[AW-1:0];

    jws_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_first_text (
        .clk   (clk),
        .we    (we_a),
        .waddr (l1_reg[AW-1:0]),
        .wdata (character),
        .raddr (i_reg[AW-1:0]),
        .rdata (rdata_a)
    );

    jws_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_second_text (
        .clk   (clk),
        .we    (we_b),
        .waddr (l2_reg[AW-1:0]),
        .wdata (character),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    // match window bounds
    assign longer      = (l1_reg > l2_reg) ? l1_reg : l2_reg;
    assign half_len    = longer >> 1;
    assign rng_calc    = (half_len != '0) ? half_len - LW'(1) : '0;
    assign win_start   = (i_reg > rng_reg) ? i_reg - rng_reg : '0;
    assign win_end_raw = (LW+1)'(i_reg) + (LW+1)'(rng_reg) + (LW+1)'(1);
    assign win_end     = (win_end_raw > (LW+1)'(l2_reg)) ? (LW+1)'(l2_reg) : win_end_raw;
    assign j_plus      = (LW+1)'(j_reg) + (LW+1)'(1);

    // divider step
    assign ge      = rem_reg >= (NW+1)'(den_reg);
    assign rem_sub = ge ? rem_reg - (NW+1)'(den_reg) : rem_reg;

    assign boost_sum = 19'(w_reg) + 19'(prod_reg[34:16]);
    assign trans     = half_reg >> 1;

    always_comb
    begin
        status.l1_zero     = (l1_reg == '0);
        status.row_done    = (i_reg >= l1_reg);
        status.win_empty   = ((LW+1)'(win_start) >= win_end);
        status.hit         = !sm_reg[j_reg[AW-1:0]] && (rdata_a == rdata_b);
        status.win_last    = (j_plus >= (LW+1)'(jend_reg));
        status.fm_i        = fm_reg[i_reg[AW-1:0]];
        status.k_in        = (j_reg < l2_reg);
        status.sm_k        = sm_reg[j_reg[AW-1:0]];
        status.common_zero = (common_reg == '0);
        status.div_last    = (cnt_reg == 5'd16);
        status.boost       = (q_reg > boost_threshold);
        status.pre_done    = (PW'(i_reg) >= PW'(prefix_limit)) || (i_reg >= l1_reg)
                             || (i_reg >= l2_reg);
        status.pre_eq      = (rdata_a == rdata_b);
    end

    always_comb
    begin
        l1_next       = l1_reg;
        l2_next       = l2_reg;
        ovf_next      = ovf_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        jend_next     = jend_reg;
        rng_next      = rng_reg;
        common_next   = common_reg;
        half_next     = half_reg;
        fm_next       = fm_reg;
        sm_next       = sm_reg;
        pre_mode_next = pre_mode_reg;
        cc_next       = cc_reg;
        ll_next       = ll_reg;
        na_next       = na_reg;
        nb_next       = nb_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;
        w_next        = w_reg;
        sim_next      = sim_reg;
        cnt_next      = cnt_reg;
        sp_next       = sp_reg;
        prod_next     = prod_reg;
        plen_next     = plen_reg;
        sim_out_next  = sim_out_reg;
        dis_out_next  = dis_out_reg;
        cc_out_next   = cc_out_reg;
        tr_out_next   = tr_out_reg;
        pl_out_next   = pl_out_reg;
        ov_out_next   = ov_out_reg;
        case (cmd)
            jws_pkg::CMD_APPEND:
            begin
                if (opcode == jws_pkg::OP_APPEND_FIRST)
                begin
                    if (we_a)
                    begin
                        l1_next = l1_reg + LW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else
                begin
                    if (we_b)
                    begin
                        l2_next = l2_reg + LW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            jws_pkg::CMD_START:
            begin
                i_next        = '0;
                j_next        = '0;
                common_next   = '0;
                half_next     = '0;
                fm_next       = '0;
                sm_next       = '0;
                pre_mode_next = 1'b0;
                plen_next     = '0;
                rng_next      = rng_calc;
                sim_next      = ((l1_reg == '0) && (l2_reg == '0)) ? jws_pkg::ONE_Q16 : '0;
            end
            jws_pkg::CMD_ROW_INIT:
            begin
                j_next    = win_start;
                jend_next = LW'(win_end);
            end
            jws_pkg::CMD_NEXT_ROW, jws_pkg::CMD_I_INC:
            begin
                i_next = i_reg + LW'(1);
            end
            jws_pkg::CMD_HIT:
            begin
                fm_next[i_reg[AW-1:0]] = 1'b1;
                sm_next[j_reg[AW-1:0]] = 1'b1;
                common_next = common_reg + LW'(1);
                i_next      = i_reg + LW'(1);
            end
            jws_pkg::CMD_J_INC:
            begin
                j_next = j_reg + LW'(1);
            end
            jws_pkg::CMD_T_INIT:
            begin
                i_next = '0;
                j_next = '0;
            end
            jws_pkg::CMD_T_CMP:
            begin
                if (rdata_a != rdata_b)
                begin
                    half_next = half_reg + LW'(1);
                end
                i_next = i_reg + LW'(1);
                j_next = j_reg + LW'(1);
            end
            jws_pkg::CMD_AR1:
            begin
                cc_next = (2*LW)'(common_reg) * (2*LW)'(common_reg);
            end
            jws_pkg::CMD_AR2:
            begin
                ll_next = (2*LW)'(l1_reg) * (2*LW)'(l2_reg);
            end
            jws_pkg::CMD_AR3:
            begin
                na_next = (3*LW+1)'(cc_reg) * ((3*LW+1)'(l1_reg) + (3*LW+1)'(l2_reg));
            end
            jws_pkg::CMD_AR4:
            begin
                nb_next = (3*LW)'(common_reg - trans) * (3*LW)'(ll_reg);
            end
            jws_pkg::CMD_AR5:
            begin
                den_next = NW'(ll_reg) * NW'(common_reg);
            end
            jws_pkg::CMD_AR6:
            begin
                den_next = (den_reg << 1) + den_reg;
                rem_next = (NW+1)'(na_reg) + (NW+1)'(nb_reg);
                q_next   = '0;
                cnt_next = '0;
            end
            jws_pkg::CMD_DIV_STEP:
            begin
                rem_next = rem_sub << 1;
                q_next   = {q_reg[15:0], ge};
                cnt_next = cnt_reg + 5'd1;
            end
            jws_pkg::CMD_SET_W:
            begin
                w_next        = q_reg;
                sim_next      = q_reg;
                i_next        = '0;
                pre_mode_next = 1'b1;
            end
            jws_pkg::CMD_B1:
            begin
                plen_next = 4'(i_reg);
                sp_next   = 18'(prefix_scale) * 18'(4'(i_reg));
            end
            jws_pkg::CMD_B2:
            begin
                prod_next = 35'(sp_reg) * 35'(jws_pkg::ONE_Q16 - w_reg);
            end
            jws_pkg::CMD_B3:
            begin
                sim_next = (boost_sum > 19'(jws_pkg::ONE_Q16)) ? jws_pkg::ONE_Q16
                                                              : 17'(boost_sum);
            end
            jws_pkg::CMD_EMIT:
            begin
                sim_out_next = sim_reg;
                dis_out_next = jws_pkg::ONE_Q16 - sim_reg;
                cc_out_next  = 7'(common_reg);
                tr_out_next  = 6'(trans);
                pl_out_next  = plen_reg;
                ov_out_next  = ovf_reg;
                l1_next      = '0;
                l2_next      = '0;
                ovf_next     = 1'b0;
            end
            default:
            begin
                l1_next = l1_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_reg  <= '0;
            l2_reg  <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            l1_reg  <= l1_next;
            l2_reg  <= l2_next;
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        jend_reg     <= jend_next;
        rng_reg      <= rng_next;
        common_reg   <= common_next;
        half_reg     <= half_next;
        fm_reg       <= fm_next;
        sm_reg       <= sm_next;
        pre_mode_reg <= pre_mode_next;
        cc_reg       <= cc_next;
        ll_reg       <= ll_next;
        na_reg       <= na_next;
        nb_reg       <= nb_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        w_reg        <= w_next;
        sim_reg      <= sim_next;
        cnt_reg      <= cnt_next;
        sp_reg       <= sp_next;
        prod_reg     <= prod_next;
        plen_reg     <= plen_next;
        sim_out_reg  <= sim_out_next;
        dis_out_reg  <= dis_out_next;
        cc_out_reg   <= cc_out_next;
        tr_out_reg   <= tr_out_next;
        pl_out_reg   <= pl_out_next;
        ov_out_reg   <= ov_out_next;
    end

    assign similarity          = sim_out_reg;
    assign dissimilarity       = dis_out_reg;
    assign common_count        = cc_out_reg;
    assign transposition_count = tr_out_reg;
    assign prefix_length       = pl_out_reg;
    assign overflow            = ov_out_reg;

endmodule

### rtl/core/jaro_winkler_similarity_core.sv
// jaro_winkler_similarity_core: top level with apb register file, sequencer and datapath
// depends on jws_pkg, jws_ctrl, jws_dp and jws_ram
//
// channel   signals                          direction
// -------   ------------------------------   ---------
// apb       psel penable pwrite paddr ...    config in, read data out
// item      item_valid item_ready            opcode, character in
// result    result_valid result_ready        similarity ... overflow out
//
// an append or ignored opcode leaves the sequencer in idle; a compare runs the
// match walk over the window positions visited, the transposition scan over the
// characters, 6 multiply steps, 17 divider steps, a prefix scan of up to
// prefix_limit characters and the boost steps
// the result register frees the item side: appends go on while a result waits
// rst_n clears lengths, overflow flag and the sequencer, and sets the config registers to their defaults

module jaro_winkler_similarity_core #(
    parameter int MAX_LEN = jws_pkg::MAX_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  character,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [16:0] similarity,
    output logic [16:0] dissimilarity,
    output logic [6:0]  common_count,
    output logic [5:0]  transposition_count,
    output logic [3:0]  prefix_length,
    output logic        overflow
);

    logic [16:0] thr_reg, thr_next;
    logic [3:0]  lim_reg, lim_next;
    logic [13:0] scl_reg, scl_next;
    logic        wr_en;

    jws_pkg::cmd_t       cmd;
    jws_pkg::dp_status_t status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        thr_next = thr_reg;
        lim_next = lim_reg;
        scl_next = scl_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                jws_pkg::REG_THRESHOLD:  thr_next = pwdata[16:0];
                jws_pkg::REG_PREFIX_LIM: lim_next = pwdata[3:0];
                jws_pkg::REG_PREFIX_SCL: scl_next = pwdata[13:0];
                default:                 thr_next = thr_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            jws_pkg::REG_THRESHOLD:  prdata = 32'(thr_reg);
            jws_pkg::REG_PREFIX_LIM: prdata = 32'(lim_reg);
            jws_pkg::REG_PREFIX_SCL: prdata = 32'(scl_reg);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= jws_pkg::THRESHOLD_DEF;
            lim_reg <= jws_pkg::PREFIX_LIM_DEF;
            scl_reg <= jws_pkg::PREFIX_SCL_DEF;
        end
        else
        begin
            thr_reg <= thr_next;
            lim_reg <= lim_next;
            scl_reg <= scl_next;
        end
    end

    jws_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .opcode       (opcode),
        .result_ready (result_ready),
        .status       (status),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .cmd          (cmd)
    );

    jws_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .opcode              (opcode),
        .character           (character),
        .boost_threshold     (thr_reg),
        .prefix_limit        (lim_reg),
        .prefix_scale        (scl_reg),
        .status              (status),
        .similarity          (similarity),
        .dissimilarity       (dissimilarity),
        .common_count        (common_count),
        .transposition_count (transposition_count),
        .prefix_length       (prefix_length),
        .overflow            (overflow)
    );

    a_sum_is_one: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (18'(similarity) + 18'(dissimilarity) == 18'(jws_pkg::ONE_Q16)))
        else $error("similarity and distance do not sum to one");

    a_trans_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (7'(transposition_count) * 7'd2 <= common_count))
        else $error("transpositions exceed matched characters");

    a_prefix_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (prefix_length != 4'd0) |-> (common_count != 7'd0))
        else $error("prefix boost without matches");

endmodule
